// ===== src/pdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, register indexes, configuration struct and divide-by-100 helper.
package pdc_pkg;

   localparam int SIG_W      = 16;
   localparam int ERR_W      = SIG_W + 1;
   localparam int GAIN_W     = 24;
   localparam int LIM_W      = 15;
   localparam int WIN_W      = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = GAIN_W;

   // Widths on the gyro damping path, where |gain_d| = 100*quo + rem.
   localparam int QUO_W       = 18;
   localparam int REM_W       = 7;
   localparam int RATE_PROD_W = 32;
   localparam int REM_PROD_W  = 22;
   localparam int DRATE_W     = RATE_PROD_W + 1;

   localparam int GI_ERR_W = GAIN_W + ERR_W;
   localparam int P_PROD_W = GAIN_W + ERR_W + 1;
   localparam int D_PROD_W = GAIN_W + ERR_W + 2;

   localparam int RATE_DIVISOR = 100;
   // floor(2^24 / 100); the estimate is low by at most one.
   localparam int RECIP_SHIFT = 24;
   localparam logic [17:0] DIV_RECIP = 18'd167772;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE           = 4'd0,
      CSR_MAX_OUTPUT     = 4'd1,
      CSR_INTEGRAL_LIMIT = 4'd2,
      CSR_GAIN_P         = 4'd3,
      CSR_GAIN_I         = 4'd4,
      CSR_GAIN_D         = 4'd5,
      CSR_ERROR_CEILING  = 4'd6,
      CSR_DEAD_ZONE      = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic                     mode;
      logic [LIM_W-1:0]         max_output;
      logic [LIM_W-1:0]         integral_limit;
      logic signed [GAIN_W-1:0] gain_p;
      logic signed [GAIN_W-1:0] gain_i;
      logic signed [GAIN_W-1:0] gain_d;
      logic                     gd_neg;
      logic [QUO_W-1:0]         gd_quo;
      logic [REM_W-1:0]         gd_rem;
      logic [WIN_W-1:0]         error_ceiling;
      logic [WIN_W-1:0]         dead_zone;
   } pdc_cfg_type;

   // Quotient of n by 100 for n below 2^24: reciprocal estimate, then one correction.
   function automatic logic [QUO_W-1:0] div100_quo(input logic [GAIN_W-1:0] n);
      logic [GAIN_W+17:0] prod;
      logic [QUO_W-1:0]   q0;
      logic [GAIN_W:0]    r0;
      prod = n * DIV_RECIP;
      q0   = prod[GAIN_W+17:RECIP_SHIFT];
      r0   = {1'b0, n} - (GAIN_W+1)'(q0) * (GAIN_W+1)'(RATE_DIVISOR);
      return (r0 >= (GAIN_W+1)'(RATE_DIVISOR)) ? q0 + QUO_W'(1) : q0;
   endfunction

endpackage

// ===== src/pdc_req_if.sv =====
`timescale 1ns / 1ps
// Sample channel: one word carries func, measurement, target and gyro rate.
interface pdc_req_if import pdc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    func;
   logic signed [SIG_W-1:0] measured;
   logic signed [SIG_W-1:0] target;
   logic signed [SIG_W-1:0] rate_sample;

   modport source (output valid, func, measured, target, rate_sample, input ready);
   modport sink   (input valid, func, measured, target, rate_sample, output ready);
endinterface

// ===== src/pdc_rsp_if.sv =====
`timescale 1ns / 1ps
// Result channel: one word carries the drive value and the held flag.
interface pdc_rsp_if import pdc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [SIG_W-1:0] drive;
   logic                    held;

   modport source (output valid, drive, held, input ready);
   modport sink   (input valid, drive, held, output ready);
endinterface

// ===== src/pdc_csr_if.sv =====
`timescale 1ns / 1ps
// Configuration write channel: register index and write data.
interface pdc_csr_if import pdc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/pdc_csr.sv =====
`timescale 1ns / 1ps
// Configuration registers, including the split of gain_d by 100 for gyro damping.
module pdc_csr import pdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pdc_csr_if.sink     csr,
   output pdc_cfg_type cfg
);

   pdc_cfg_type              cfg_ff;
   pdc_cfg_type              cfg_in;
   logic signed [GAIN_W-1:0] wr_gain;
   logic [GAIN_W-1:0]        wr_mag;
   logic [QUO_W-1:0]         wr_quo;
   logic [REM_W-1:0]         wr_rem;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      wr_gain = csr.data;
      wr_mag  = wr_gain[GAIN_W-1] ? GAIN_W'(-wr_gain) : GAIN_W'(wr_gain);
      wr_quo  = div100_quo(wr_mag);
      wr_rem  = REM_W'(wr_mag - GAIN_W'(wr_quo) * GAIN_W'(RATE_DIVISOR));

      cfg_in = cfg_ff;
      if (csr.valid && csr.ready) begin
         case (csr.index)
            CSR_MODE:           cfg_in.mode           = csr.data[0];
            CSR_MAX_OUTPUT:     cfg_in.max_output     = csr.data[LIM_W-1:0];
            CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr.data[LIM_W-1:0];
            CSR_GAIN_P:         cfg_in.gain_p         = wr_gain;
            CSR_GAIN_I:         cfg_in.gain_i         = wr_gain;
            CSR_GAIN_D: begin
               cfg_in.gain_d = wr_gain;
               cfg_in.gd_neg = wr_gain[GAIN_W-1];
               cfg_in.gd_quo = wr_quo;
               cfg_in.gd_rem = wr_rem;
            end
            CSR_ERROR_CEILING:  cfg_in.error_ceiling  = csr.data[WIN_W-1:0];
            CSR_DEAD_ZONE:      cfg_in.dead_zone      = csr.data[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/pid_position_delta_controller.sv =====
`timescale 1ns / 1ps
// Top level: positional / incremental PID controller, three stages and a result register.
//
//   channel  | dir | handshake   | payload
//   ---------+-----+-------------+-------------------------------------------
//   req_ch   | in  | valid/ready | func, measured, target, rate_sample
//   rsp_ch   | out | valid/ready | drive, held
//   csr_ch   | in  | valid/ready | index, data (ready is always high)
//
// One word is taken per cycle unless a stalled result has backed up to stage one.
// Stage one forms the error and the gyro products, stage two finishes the divide by
// 100, stage three runs the PID update against the error history, integral and last
// output, which change only when its word moves into the result register.
// Reset clears configuration, controller state and all valid flags.
// A stalled result holds its stage; earlier stages keep filling until they are full.
module pid_position_delta_controller import pdc_pkg::*; #(
   parameter int GAIN_FRAC_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   pdc_req_if.sink    req_ch,
   pdc_rsp_if.source  rsp_ch,
   pdc_csr_if.sink    csr_ch
);

   localparam int QW = LIM_W + 1 + GAIN_FRAC_BITS;
   localparam int SW = ((QW > D_PROD_W) ? QW : D_PROD_W) + 2;
   localparam logic [GAIN_W-1:0] GI_THR =
      GAIN_W'(((1 << GAIN_FRAC_BITS) + 999) / 1000);

   pdc_cfg_type cfg;

   pdc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   // Flow control.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready, out_free;

   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s3_ready     = !s3_valid_ff || out_free;
   assign s2_ready     = !s2_valid_ff || s3_ready;
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_ch.ready = s1_ready;

   // Stage one: input register.
   logic                    s1_func_ff;
   logic signed [SIG_W-1:0] s1_meas_ff, s1_tgt_ff, s1_rate_ff;

   logic signed [ERR_W-1:0]   s1_err;
   logic [ERR_W-1:0]          s1_mag;
   logic                      s1_hold;
   logic [SIG_W-1:0]          s1_rate_mag;
   logic [RATE_PROD_W-1:0]    s1_ar;
   logic [REM_PROD_W-1:0]     s1_br;
   logic                      s1_prod_neg;
   logic signed [GI_ERR_W-1:0] s1_gi_err;

   always_comb begin
      s1_err  = ERR_W'(s1_tgt_ff) - ERR_W'(s1_meas_ff);
      s1_mag  = s1_err[ERR_W-1] ? ERR_W'(-s1_err) : ERR_W'(s1_err);
      s1_hold = !s1_func_ff &&
                ((cfg.error_ceiling != '0 && s1_mag > ERR_W'(cfg.error_ceiling)) ||
                 (cfg.dead_zone != '0 && s1_mag < ERR_W'(cfg.dead_zone)));
      s1_rate_mag = s1_rate_ff[SIG_W-1] ? SIG_W'(-s1_rate_ff) : SIG_W'(s1_rate_ff);
      s1_ar       = RATE_PROD_W'(cfg.gd_quo) * RATE_PROD_W'(s1_rate_mag);
      s1_br       = REM_PROD_W'(cfg.gd_rem) * REM_PROD_W'(s1_rate_mag);
      s1_prod_neg = cfg.gd_neg ^ s1_rate_ff[SIG_W-1];
      s1_gi_err   = cfg.gain_i * s1_err;
   end

   // Stage two: finish |gain_d*rate|/100 and apply the sign of the damping term.
   logic                       s2_func_ff, s2_hold_ff, s2_prod_neg_ff;
   logic signed [ERR_W-1:0]    s2_err_ff;
   logic [RATE_PROD_W-1:0]     s2_ar_ff;
   logic [REM_PROD_W-1:0]      s2_br_ff;
   logic signed [GI_ERR_W-1:0] s2_gi_err_ff;

   logic [RATE_PROD_W-1:0]     s2_dq;
   logic signed [DRATE_W-1:0]  s2_d_rate;

   always_comb begin
      s2_dq = s2_ar_ff + RATE_PROD_W'(div100_quo(GAIN_W'(s2_br_ff)));
      // The damping term is the negated product, so a negative product gives +q.
      s2_d_rate = s2_prod_neg_ff ? DRATE_W'(s2_dq) : -DRATE_W'(s2_dq);
   end

   // Stage three: PID update against the stored state.
   logic                       s3_func_ff, s3_hold_ff;
   logic signed [ERR_W-1:0]    s3_err_ff;
   logic signed [GI_ERR_W-1:0] s3_gi_err_ff;
   logic signed [DRATE_W-1:0]  s3_d_rate_ff;

   logic signed [ERR_W-1:0] error_prev_ff, error_prev_in;
   logic signed [ERR_W-1:0] error_prev2_ff, error_prev2_in;
   logic signed [QW-1:0]    integral_acc_ff, integral_acc_in;
   logic signed [QW-1:0]    last_output_ff, last_output_in;

   logic signed [ERR_W:0]      diff1;
   logic signed [ERR_W+1:0]    diff2;
   logic signed [ERR_W:0]      p_opnd;
   logic signed [ERR_W+1:0]    d_opnd;
   logic signed [P_PROD_W-1:0] p_prod;
   logic signed [D_PROD_W-1:0] d_prod;
   logic [GAIN_W-1:0]          gi_mag;
   logic                       gi_small;
   logic signed [SW-1:0]       int_lim, out_lim, int_pre, int_clamped;
   logic signed [SW-1:0]       t_last, t_p, t_i, t_d, sum, res_clamped;
   logic signed [QW-1:0]       result;
   logic [QW-1:0]              res_mag;
   logic [LIM_W-1:0]           drive_mag;
   logic signed [SIG_W-1:0]    drive_calc;
   logic                       s3_fire;

   always_comb begin
      diff1  = (ERR_W+1)'(s3_err_ff) - (ERR_W+1)'(error_prev_ff);
      diff2  = (ERR_W+2)'(s3_err_ff) - ((ERR_W+2)'(error_prev_ff) <<< 1)
               + (ERR_W+2)'(error_prev2_ff);
      p_opnd = cfg.mode ? diff1 : (ERR_W+1)'(s3_err_ff);
      d_opnd = cfg.mode ? diff2 : (ERR_W+2)'(diff1);
      p_prod = cfg.gain_p * p_opnd;
      d_prod = cfg.gain_d * d_opnd;

      gi_mag   = cfg.gain_i[GAIN_W-1] ? GAIN_W'(-cfg.gain_i) : GAIN_W'(cfg.gain_i);
      gi_small = gi_mag < GI_THR;

      int_lim = SW'({cfg.integral_limit, {GAIN_FRAC_BITS{1'b0}}});
      out_lim = SW'({cfg.max_output, {GAIN_FRAC_BITS{1'b0}}});

      // Incremental mode keeps only the clamped gain_i*error; positional mode sums,
      // except that a gyro-damped step with a negligible gain_i restarts from zero.
      if (cfg.mode) begin
         int_pre = SW'(s3_gi_err_ff);
      end else if (s3_func_ff && gi_small) begin
         int_pre = '0;
      end else begin
         int_pre = SW'(integral_acc_ff) + SW'(s3_gi_err_ff);
      end
      if (int_pre > int_lim) begin
         int_clamped = int_lim;
      end else if (int_pre < -int_lim) begin
         int_clamped = -int_lim;
      end else begin
         int_clamped = int_pre;
      end

      t_last = cfg.mode ? SW'(last_output_ff) : '0;
      t_p    = SW'(p_prod);
      t_i    = int_clamped;
      t_d    = (!cfg.mode && s3_func_ff) ? SW'(s3_d_rate_ff) : SW'(d_prod);
      sum    = t_last + t_p + t_i + t_d;

      if (sum > out_lim) begin
         res_clamped = out_lim;
      end else if (sum < -out_lim) begin
         res_clamped = -out_lim;
      end else begin
         res_clamped = sum;
      end
      result = QW'(res_clamped);

      // Drop the fraction bits, rounding toward zero.
      res_mag    = result[QW-1] ? QW'(-result) : QW'(result);
      drive_mag  = res_mag[GAIN_FRAC_BITS +: LIM_W];
      drive_calc = result[QW-1] ? -{1'b0, drive_mag} : {1'b0, drive_mag};

      s3_fire = s3_valid_ff && out_free;

      error_prev_in   = error_prev_ff;
      error_prev2_in  = error_prev2_ff;
      integral_acc_in = integral_acc_ff;
      last_output_in  = last_output_ff;
      if (s3_fire && !s3_hold_ff) begin
         error_prev_in   = s3_err_ff;
         error_prev2_in  = error_prev_ff;
         integral_acc_in = QW'(int_clamped);
         if (cfg.mode) begin
            last_output_in = result;
         end
      end
   end

   // Result register.
   logic signed [SIG_W-1:0] rsp_drive_ff;
   logic                    rsp_held_ff;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.drive = rsp_drive_ff;
   assign rsp_ch.held  = rsp_held_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         s3_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         error_prev_ff   <= '0;
         error_prev2_ff  <= '0;
         integral_acc_ff <= '0;
         last_output_ff  <= '0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s3_valid_ff;
         end
         error_prev_ff   <= error_prev_in;
         error_prev2_ff  <= error_prev2_in;
         integral_acc_ff <= integral_acc_in;
         last_output_ff  <= last_output_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_func_ff <= req_ch.func;
         s1_meas_ff <= req_ch.measured;
         s1_tgt_ff  <= req_ch.target;
         s1_rate_ff <= req_ch.rate_sample;
      end
      if (s2_ready) begin
         s2_func_ff     <= s1_func_ff;
         s2_hold_ff     <= s1_hold;
         s2_err_ff      <= s1_err;
         s2_ar_ff       <= s1_ar;
         s2_br_ff       <= s1_br;
         s2_prod_neg_ff <= s1_prod_neg;
         s2_gi_err_ff   <= s1_gi_err;
      end
      if (s3_ready) begin
         s3_func_ff   <= s2_func_ff;
         s3_hold_ff   <= s2_hold_ff;
         s3_err_ff    <= s2_err_ff;
         s3_gi_err_ff <= s2_gi_err_ff;
         s3_d_rate_ff <= s2_d_rate;
      end
      if (out_free) begin
         rsp_drive_ff <= s3_hold_ff ? '0 : drive_calc;
         rsp_held_ff  <= s3_hold_ff;
      end
   end

endmodule

// ===== src/pdc_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the PID controller and its bind to the top level.
module pdc_checker import pdc_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic signed [SIG_W-1:0] rsp_drive,
   input logic                    rsp_held
);

   // A word held by the error window always carries a zero drive.
   a_held_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_held) |-> (rsp_drive == '0))
      else $error("held word with nonzero drive");

   // The output clamp never lets the most negative code through.
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive != {1'b1, {(SIG_W-1){1'b0}}}))
      else $error("drive outside the clamp range");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   // A stalled word stays and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_drive) && $stable(rsp_held)))
      else $error("stalled result word changed");

endmodule

bind pid_position_delta_controller pdc_checker u_pdc_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_drive (rsp_ch.drive),
   .rsp_held  (rsp_ch.held)
);
